// ===== hw/rtl/ccl_pkg.sv =====
package ccl_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OpRxByte   = 2'd0,
    OpTake     = 2'd1,
    OpTakeNode = 2'd2,
    OpNone     = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic CfgIntervalMin = 1'b0;
  localparam logic CfgIntervalMax = 1'b1;

  localparam logic [31:0] IntervalMinRst = 32'd15;
  localparam logic [31:0] IntervalMaxRst = 32'd604800;

  // Characters
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharF     = 8'h46;
  localparam logic [7:0] CharG     = 8'h47;

  // Expected prefix character for each prefix phase
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = CharC;
      2'd1:    ch = CharF;
      2'd2:    ch = CharG;
      default: ch = CharSpace;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/config_command_line_parser.sv =====
// A request is registered in the input register at acceptance; its take result is then
// registered in the result register. Throughput: one request per cycle unless a stalled
// take result holds the input register; the parse state and pending slot update in the
// single stage between the input register and the result register.
// Reset: parse state, line count and the pending slot clear; interval bounds return to
// 15 and 604800.
module config_command_line_parser #(
  parameter int LINE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] wanted_node_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        taken_o,
  output logic [31:0] node_out_o,
  output logic [31:0] transaction_out_o,
  output logic [31:0] revision_out_o,
  output logic [31:0] interval_out_o,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int CntW = $clog2(LINE_BYTES);
  localparam logic [CntW-1:0] CntLast = CntW'(LINE_BYTES - 1);

  // Parse phase codes
  localparam logic [2:0] PhPrefix0 = 3'd0;
  localparam logic [2:0] PhField0  = 3'd4;
  localparam logic [2:0] PhField3  = 3'd7;

  // Configuration registers
  logic [31:0] interval_min_q, interval_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_min_q <= ccl_pkg::IntervalMinRst;
      interval_max_q <= ccl_pkg::IntervalMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ccl_pkg::CfgIntervalMin: interval_min_q <= cfg_wdata_i;
        default:                 interval_max_q <= cfg_wdata_i;
      endcase
    end
  end

  // Input register
  logic        s1_valid_q;
  logic [1:0]  s1_op_q;
  logic [7:0]  s1_byte_q;
  logic [31:0] s1_node_q;
  logic        s1_has_result;
  logic        advance;
  logic        in_accept;
  logic        out_valid_q;

  assign s1_has_result = (s1_op_q == ccl_pkg::OpTake) || (s1_op_q == ccl_pkg::OpTakeNode);
  assign advance       = !(s1_has_result && out_valid_q && out_stall_i);
  assign in_stall_o    = s1_valid_q && !advance;
  assign in_accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= operation_i;
      s1_byte_q <= rx_byte_i;
      s1_node_q <= wanted_node_i;
    end
  end

  // Parse state and pending slot
  logic [CntW-1:0] count_q, count_d;
  logic [2:0]      phase_q, phase_d;
  logic            bad_q, bad_d;
  logic            ended_q, ended_d;
  logic            digit_q, digit_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     fs_q [3];
  logic            fs_we;
  logic [1:0]      fs_idx;
  logic            pend_valid_q, pend_valid_d;
  logic [31:0]     pend_q [4];
  logic            pend_we;

  logic            do_step;
  logic            is_eol, is_digit, commit, hit;
  logic [35:0]     acc_next;

  assign do_step  = s1_valid_q && advance;
  assign is_eol   = (s1_byte_q == ccl_pkg::CharLf) || (s1_byte_q == ccl_pkg::CharCr);
  assign is_digit = (s1_byte_q >= ccl_pkg::CharZero) && (s1_byte_q <= ccl_pkg::CharNine);
  // acc * 10 + digit
  assign acc_next = 36'({acc_q, 3'b000}) + 36'({acc_q, 1'b0})
                  + 36'(4'(s1_byte_q - ccl_pkg::CharZero));
  assign fs_idx   = 2'(phase_q - PhField0);

  assign commit = !bad_q && (phase_q == PhField3) && digit_q
               && (fs_q[0] != '0) && (fs_q[1] != '0) && (fs_q[2] != '0)
               && (acc_q >= interval_min_q) && (acc_q <= interval_max_q);

  assign hit = pend_valid_q
            && ((s1_op_q == ccl_pkg::OpTake) || (pend_q[0] == s1_node_q));

  always_comb begin
    count_d      = count_q;
    phase_d      = phase_q;
    bad_d        = bad_q;
    ended_d      = ended_q;
    digit_d      = digit_q;
    acc_d        = acc_q;
    fs_we        = 1'b0;
    pend_we      = 1'b0;
    pend_valid_d = pend_valid_q;
    if (do_step) begin
      unique case (s1_op_q)
        ccl_pkg::OpRxByte: begin
          if (is_eol) begin
            // close the line, latch a good command, restart
            if (count_q != '0) begin
              pend_we = commit;
              if (commit) begin
                pend_valid_d = 1'b1;
              end
              count_d = '0;
              phase_d = PhPrefix0;
              bad_d   = 1'b0;
              ended_d = 1'b0;
              digit_d = 1'b0;
              acc_d   = '0;
            end
          end else if (count_q < CntLast) begin
            count_d = count_q + 1'b1;
            if (!ended_q && !bad_q) begin
              priority if (s1_byte_q == ccl_pkg::CharNul) begin
                ended_d = 1'b1;
              end else if (phase_q < PhField0) begin
                // match the prefix
                if (s1_byte_q == ccl_pkg::prefix_char(phase_q[1:0])) begin
                  phase_d = phase_q + 1'b1;
                end else begin
                  bad_d = 1'b1;
                end
              end else if (is_digit) begin
                // accumulate, reject on 32-bit overflow
                if (acc_next[35:32] != '0) begin
                  bad_d = 1'b1;
                end else begin
                  acc_d   = acc_next[31:0];
                  digit_d = 1'b1;
                end
              end else if (!digit_q || phase_q == PhField3
                           || s1_byte_q != ccl_pkg::CharSpace) begin
                bad_d = 1'b1;
              end else begin
                // store the field and move to the next
                fs_we   = 1'b1;
                acc_d   = '0;
                digit_d = 1'b0;
                phase_d = phase_q + 1'b1;
              end
            end
          end else begin
            // drop the overflowing byte and restart the line
            count_d = '0;
            phase_d = PhPrefix0;
            bad_d   = 1'b0;
            ended_d = 1'b0;
            digit_d = 1'b0;
            acc_d   = '0;
          end
        end
        ccl_pkg::OpTake, ccl_pkg::OpTakeNode: begin
          if (hit) begin
            pend_valid_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      phase_q      <= PhPrefix0;
      bad_q        <= 1'b0;
      ended_q      <= 1'b0;
      digit_q      <= 1'b0;
      acc_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      phase_q      <= phase_d;
      bad_q        <= bad_d;
      ended_q      <= ended_d;
      digit_q      <= digit_d;
      acc_q        <= acc_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Field store and pending slot payload
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_q[fs_idx] <= acc_q;
    end
    if (pend_we) begin
      pend_q[0] <= fs_q[0];
      pend_q[1] <= fs_q[1];
      pend_q[2] <= fs_q[2];
      pend_q[3] <= acc_q;
    end
  end

  // Result register
  logic        load_out;
  logic        taken_q;
  logic [31:0] node_q, trans_q, rev_q, ivl_q;

  assign load_out = do_step && s1_has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      taken_q <= hit;
      node_q  <= hit ? pend_q[0] : '0;
      trans_q <= hit ? pend_q[1] : '0;
      rev_q   <= hit ? pend_q[2] : '0;
      ivl_q   <= hit ? pend_q[3] : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign taken_o           = taken_q;
  assign node_out_o        = node_q;
  assign transaction_out_o = trans_q;
  assign revision_out_o    = rev_q;
  assign interval_out_o    = ivl_q;

endmodule

// ===== verif/tb_config_command_line_parser.sv =====
module tb_config_command_line_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineBytes = 64;
  localparam int PrefixLen = 4;
  localparam int LastField = 7;
  localparam int StuckLimit = 2000;
  localparam int PhaseItems = 250;
  // "CFG " with the first character in the low byte
  localparam logic [31:0] CmdPrefix = {ccl_pkg::CharSpace, ccl_pkg::CharG, ccl_pkg::CharF,
                                       ccl_pkg::CharC};

  typedef struct packed {
    logic        taken;
    logic [31:0] node;
    logic [31:0] txn;
    logic [31:0] rev;
    logic [31:0] ivl;
  } take_t;

  localparam take_t NoTake = '0;

  typedef struct {
    ccl_pkg::op_e op;
    logic [7:0]   lead;
    int           lead_n;
    string        text;
    logic [31:0]  node;
    bit           known;
    take_t        want;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = ccl_pkg::OpNone;
  logic [7:0]  rx_byte_i = '0;
  logic [31:0] wanted_node_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        taken_o;
  logic [31:0] node_out_o;
  logic [31:0] transaction_out_o;
  logic [31:0] revision_out_o;
  logic [31:0] interval_out_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = ccl_pkg::CfgIntervalMin;
  logic [31:0] cfg_wdata_i = '0;

  // Parser mirror: line state, pending slot and interval bounds
  int          line_len = 0;
  int          parse_step = 0;
  bit          line_broken = 1'b0;
  bit          text_done = 1'b0;
  bit          have_digit = 1'b0;
  logic [31:0] field_acc = '0;
  logic [31:0] line_fields [3];
  logic [31:0] slot_fields [4];
  bit          slot_full = 1'b0;
  logic [31:0] bound_lo = ccl_pkg::IntervalMinRst;
  logic [31:0] bound_hi = ccl_pkg::IntervalMaxRst;

  take_t       expected_takes[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          stall_left = 0;
  bit          steady = 1'b0;

  config_command_line_parser #(
    .LINE_BYTES(LineBytes)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .rx_byte_i        (rx_byte_i),
    .wanted_node_i    (wanted_node_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .taken_o          (taken_o),
    .node_out_o       (node_out_o),
    .transaction_out_o(transaction_out_o),
    .revision_out_o   (revision_out_o),
    .interval_out_o   (interval_out_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void restart_line();
    line_len = 0;
    parse_step = 0;
    line_broken = 1'b0;
    text_done = 1'b0;
    have_digit = 1'b0;
    field_acc = '0;
  endfunction

  // Advance the field parse by one counted character
  function automatic void feed_char(logic [7:0] c);
    logic [35:0] nxt;
    if (text_done || line_broken) return;
    if (c == ccl_pkg::CharNul) begin
      text_done = 1'b1;
      return;
    end
    if (parse_step < PrefixLen) begin
      if (c == CmdPrefix[parse_step*8 +: 8]) parse_step++;
      else line_broken = 1'b1;
      return;
    end
    if (c >= ccl_pkg::CharZero && c <= ccl_pkg::CharNine) begin
      nxt = {4'd0, field_acc} * 36'd10 + 36'(c - ccl_pkg::CharZero);
      if (nxt > 36'hFFFF_FFFF) begin
        line_broken = 1'b1;
      end else begin
        field_acc = nxt[31:0];
        have_digit = 1'b1;
      end
      return;
    end
    if (!have_digit || parse_step >= LastField || c != ccl_pkg::CharSpace) begin
      line_broken = 1'b1;
      return;
    end
    line_fields[parse_step - PrefixLen] = field_acc;
    field_acc = '0;
    have_digit = 1'b0;
    parse_step++;
  endfunction

  // Judge the finished line and load the slot when it holds
  function automatic void close_line();
    if (!line_broken && parse_step == LastField && have_digit &&
        line_fields[0] != 0 && line_fields[1] != 0 && line_fields[2] != 0 &&
        field_acc >= bound_lo && field_acc <= bound_hi) begin
      slot_fields[0] = line_fields[0];
      slot_fields[1] = line_fields[1];
      slot_fields[2] = line_fields[2];
      slot_fields[3] = field_acc;
      slot_full = 1'b1;
    end
    restart_line();
  endfunction

  // Apply one accepted request; return 1 when it produces a take result
  function automatic bit advance_parser(input ccl_pkg::op_e op, input logic [7:0] b,
                                        input logic [31:0] node, output take_t res);
    res = NoTake;
    if (op == ccl_pkg::OpRxByte) begin
      if (b == ccl_pkg::CharLf || b == ccl_pkg::CharCr) begin
        if (line_len != 0) close_line();
      end else if (line_len < LineBytes - 1) begin
        line_len++;
        feed_char(b);
      end else begin
        restart_line();
      end
      return 1'b0;
    end
    if (op == ccl_pkg::OpNone) return 1'b0;
    if (slot_full && (op == ccl_pkg::OpTake || slot_fields[0] == node)) begin
      res = {1'b1, slot_fields[0], slot_fields[1], slot_fields[2], slot_fields[3]};
      slot_full = 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Offer one request, hold it until accepted, then record the expected take
  task automatic send_request(ccl_pkg::op_e op, logic [7:0] b, logic [31:0] node,
                              bit known = 1'b0, take_t want = NoTake);
    take_t res;
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    rx_byte_i <= b;
    wanted_node_i <= node;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op != ccl_pkg::OpNone) requests_sent++;
    if (advance_parser(op, b, node, res)) expected_takes.push_back(known ? want : res);
  endtask

  // Hold off until every take result is back and the last bytes are parsed
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_takes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_bounds(logic [31:0] lo, logic [31:0] hi);
    cfg_we_i <= 1'b1;
    cfg_index_i <= ccl_pkg::CfgIntervalMin;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    bound_lo = lo;
    cfg_index_i <= ccl_pkg::CfgIntervalMax;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    bound_hi = hi;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_line(string text, logic [7:0] lead = ccl_pkg::CharNul,
                                   int lead_n = 0);
    script.push_back('{ccl_pkg::OpRxByte, lead, lead_n, text, 32'd0, 1'b0, NoTake});
  endfunction

  function automatic void add_take(ccl_pkg::op_e op, logic [31:0] node, bit known = 1'b0,
                                   take_t want = NoTake);
    script.push_back('{op, ccl_pkg::CharNul, 0, "", node, known, want});
  endfunction

  // Decimal text for one field; the interval favors the current bounds
  function automatic string field_text(bit interval);
    longint unsigned v;
    longint unsigned span;
    logic [31:0] w;
    int r;
    string s;
    r = $urandom_range(0, 99);
    if (interval) begin
      if (r < 15) v = 64'(bound_lo);
      else if (r < 30) v = 64'(bound_hi);
      else if (r < 38) begin
        w = bound_lo - 32'd1;
        v = 64'(w);
      end else if (r < 46) begin
        w = bound_hi + 32'd1;
        v = 64'(w);
      end else if (r < 92 && bound_lo <= bound_hi) begin
        span = {32'd0, bound_hi} - {32'd0, bound_lo} + 64'd1;
        v = {32'd0, bound_lo} + ({$urandom, $urandom} % span);
      end else v = 64'($urandom);
    end else begin
      if (r < 8) v = 64'd0;
      else if (r < 40) v = 64'($urandom_range(1, 9));
      else if (r < 85) v = 64'($urandom);
      else if (r < 93) v = 64'hFFFF_FFFF;
      else v = 64'h1_0000_0000 + 64'($urandom_range(0, 1000));
    end
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 19) == 0) s = {"0", s};
    return s;
  endfunction

  // Well-formed command line with random content, now and then damaged
  task automatic send_random_line();
    string s;
    logic [7:0] seq[$];
    int pos;
    s = "CFG";
    for (int f = 0; f < 4; f++) s = {s, " ", field_text(f == 3)};
    for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
    if ($urandom_range(0, 99) < 25) begin
      pos = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 4))
        0: seq[pos] = 8'($urandom);                   // garble one character
        1: seq.insert(pos, ccl_pkg::CharNul);          // end the text early
        2: seq.delete(pos);                            // lose one character
        3: seq.insert(pos, ccl_pkg::CharSpace);        // doubled separator
        default: begin                                 // pad near or past the line limit
          pos = $urandom_range(60, 70);
          while (seq.size() < pos) seq.push_back(8'($urandom_range(33, 126)));
        end
      endcase
    end
    seq.push_back($urandom_range(0, 1) ? ccl_pkg::CharCr : ccl_pkg::CharLf);
    if ($urandom_range(0, 9) == 0) seq.push_back(ccl_pkg::CharLf);
    foreach (seq[i]) send_request(ccl_pkg::OpRxByte, seq[i], $urandom);
  endtask

  task automatic run_phase(int quota);
    int target;
    int pick;
    int burst;
    target = requests_sent + quota;
    steady = 1'b0;
    while (requests_sent < target) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) steady = !steady;
      if (pick < 2) begin
        drain();
      end else if (pick < 55) begin
        send_random_line();
      end else if (pick < 82) begin
        if ($urandom_range(0, 1)) begin
          send_request(ccl_pkg::OpTake, 8'($urandom), $urandom);
        end else begin
          send_request(ccl_pkg::OpTakeNode, 8'($urandom),
                       (slot_full && $urandom_range(0, 3) != 0) ? slot_fields[0] : $urandom);
        end
      end else if (pick < 95) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_request(ccl_pkg::OpRxByte, 8'($urandom), $urandom);
        if ($urandom_range(0, 1)) send_request(ccl_pkg::OpRxByte, ccl_pkg::CharLf, $urandom);
      end else begin
        send_request(ccl_pkg::OpNone, 8'($urandom), $urandom);
      end
    end
  endtask

  // Check each accepted take result and drive random output stalls
  always @(posedge clk_i) begin : result_side
    take_t got;
    take_t want;
    int g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {taken_o, node_out_o, transaction_out_o, revision_out_o, interval_out_o};
      if (expected_takes.size() == 0) begin
        report_mismatch("result with no request pending", got.node, 32'd0);
      end else begin
        want = expected_takes.pop_front();
        if (got.taken !== want.taken) report_mismatch("taken", 32'(got.taken), 32'(want.taken));
        if (got.node !== want.node) report_mismatch("node_out", got.node, want.node);
        if (got.txn !== want.txn) report_mismatch("transaction_out", got.txn, want.txn);
        if (got.rev !== want.rev) report_mismatch("revision_out", got.rev, want.rev);
        if (got.ivl !== want.ivl) report_mismatch("interval_out", got.ivl, want.ivl);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      g = pick_gap();
      if (g != 0) begin
        stall_left = g - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    @(posedge rst_ni);
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] phase_lo [6];
    logic [31:0] phase_hi [6];
    phase_lo[0] = 32'd0;         phase_hi[0] = 32'hFFFF_FFFF;
    phase_lo[1] = 32'hFFFF_FFFF; phase_hi[1] = 32'hFFFF_FFFF;
    phase_lo[2] = 32'd0;         phase_hi[2] = 32'd0;
    phase_lo[3] = ccl_pkg::IntervalMinRst; phase_hi[3] = ccl_pkg::IntervalMaxRst;
    phase_lo[4] = $urandom_range(1, 1000);
    phase_hi[4] = phase_lo[4] + $urandom_range(0, 5000);
    phase_lo[5] = 32'd100;       phase_hi[5] = 32'd50;

    // Directed lines and takes: reset bounds, field extremes, rejected lines
    add_take(ccl_pkg::OpTake, 32'd0, 1'b1, NoTake);
    add_take(ccl_pkg::OpTakeNode, 32'd0, 1'b1, NoTake);
    add_line("CFG 1 2 3 15\n");
    add_take(ccl_pkg::OpTake, 32'd0, 1'b1, {1'b1, 32'd1, 32'd2, 32'd3, 32'd15});
    add_line("CFG 4294967295 4294967295 4294967295 604800\015");
    add_take(ccl_pkg::OpTakeNode, 32'd5, 1'b1, NoTake);
    add_take(ccl_pkg::OpNone, 32'hFFFF_FFFF);
    add_take(ccl_pkg::OpTakeNode, 32'hFFFF_FFFF, 1'b1,
             {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd604800});
    add_line("CFG 4294967296 1 1 20\n");
    add_line("\015\n");
    add_line("CFG 7 8 9 14\n");
    add_line("CFG 7 8 9 604801\n");
    add_line("CFG 0 8 9 100\n");
    add_line("CFG 1 2 3\n");
    add_line("CFG 1 2 3 20 \n");
    add_line("CFG 1  2 3 20\n");
    add_line("cfg 1 2 3 20\n");
    add_take(ccl_pkg::OpTake, 32'd0, 1'b1, NoTake);
    add_line("CFG 10 20 30 40");
    add_line("junk 9\n", ccl_pkg::CharNul, 1);
    add_take(ccl_pkg::OpTake, 32'd0, 1'b1, {1'b1, 32'd10, 32'd20, 32'd30, 32'd40});
    add_line("CFG 5 6 7 30\n", 8'hFF, LineBytes);
    add_take(ccl_pkg::OpTake, 32'd0, 1'b1, {1'b1, 32'd5, 32'd6, 32'd7, 32'd30});
    add_line("CFG 3 03 3 99\n");
    add_take(ccl_pkg::OpTakeNode, 32'd3);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      if (script[r].op == ccl_pkg::OpRxByte) begin
        repeat (script[r].lead_n) send_request(ccl_pkg::OpRxByte, script[r].lead, $urandom);
        for (int i = 0; i < script[r].text.len(); i++) begin
          send_request(ccl_pkg::OpRxByte, script[r].text[i], $urandom);
        end
      end else begin
        send_request(script[r].op, 8'($urandom), script[r].node, script[r].known,
                     script[r].want);
      end
    end
    drain();

    // Random traffic under each pair of interval bounds
    for (int p = 0; p < 6; p++) begin
      set_bounds(phase_lo[p], phase_hi[p]);
      run_phase(PhaseItems);
      drain();
    end

    while (expected_takes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
